FILE: sv/okdr_pkg.sv
package okdr_pkg;

  // Default table depth
  localparam int unsigned TABLE_DEPTH_DEF = 128;

  // Field widths fixed by the item formats
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned DCOUNT_W = 8;

  // Input item
  typedef struct packed {
    logic signed [VALUE_W-1:0] item_value;
    logic                      set_last;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic signed [VALUE_W-1:0] echo_value;
    logic                      keep_flag;
    logic [DCOUNT_W-1:0]       distinct_count;
    logic                      overflow_flag;
    logic                      end_of_set;
  } out_item_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture a new item and restart the scan
    logic issue;   // read the next table entry
    logic finish;  // form the result, update the table
  } okdr_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic all_issued;  // every stored entry has been read
    logic hit;         // the item matches a stored entry
    logic out_free;    // the result register can take a new item
  } okdr_sts_t;

  // Controller states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SCAN = 2'b10
  } okdr_state_t;

endpackage

FILE: sv/okdr_ram.sv
module okdr_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/okdr_ctrl.sv
module okdr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  okdr_pkg::okdr_sts_t sts,
  output okdr_pkg::okdr_cmd_t cmd
);

  import okdr_pkg::*;

  okdr_state_t state_r, state_nxt;
  logic        done;

  // Scan ends on a match or once every entry has been compared
  assign done = sts.hit || sts.all_issued;

  // Drive commands and next state
  always_comb begin
    state_nxt  = state_r;
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.issue  = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.issue = !done;
        if (done && sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: sv/okdr_dp.sv
module okdr_dp #(
  parameter int unsigned TABLE_DEPTH = okdr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  okdr_pkg::in_item_t  in_data,
  input  okdr_pkg::okdr_cmd_t cmd,
  output okdr_pkg::okdr_sts_t sts,
  output logic                out_valid,
  input  logic                out_ready,
  output okdr_pkg::out_item_t out_data
);

  import okdr_pkg::*;

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(TABLE_DEPTH);

  in_item_t           item_r;
  logic [CW-1:0]      count_r, count_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic               chk_r;
  logic               hit_r, hit_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_r, out_nxt;
  logic [VALUE_W-1:0] rd_data;
  logic               hit_now;
  logic               hit_any;
  logic               store;
  logic [CW-1:0]      count_new;

  // Seen-values table
  okdr_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk    (clk),
    .wr_en  (store),
    .wr_addr(count_r[AW-1:0]),
    .wr_data(item_r.item_value),
    .rd_en  (cmd.issue),
    .rd_addr(idx_r[AW-1:0]),
    .rd_data(rd_data)
  );

  // Compare the entry read last cycle
  assign hit_now = chk_r && (rd_data == item_r.item_value);
  assign hit_any = hit_now || hit_r;

  // Store a new value while there is room
  assign store     = cmd.finish && !hit_any && (count_r != FULL);
  assign count_new = store ? count_r + CW'(1) : count_r;

  assign sts.all_issued = (idx_r == count_r);
  assign sts.hit        = hit_any;
  assign sts.out_free   = !out_valid_r || out_ready;

  // Advance scan pointer, count and result
  always_comb begin
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    count_nxt     = count_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load) begin
      idx_nxt = '0;
      hit_nxt = 1'b0;
    end else begin
      if (cmd.issue) begin
        idx_nxt = idx_r + CW'(1);
      end
      if (hit_now) begin
        hit_nxt = 1'b1;
      end
    end
    if (cmd.finish) begin
      out_nxt.echo_value     = item_r.item_value;
      out_nxt.keep_flag      = store;
      out_nxt.distinct_count = DCOUNT_W'(count_new);
      out_nxt.overflow_flag  = !hit_any && (count_r == FULL);
      out_nxt.end_of_set     = item_r.set_last;
      out_valid_nxt          = 1'b1;
      // Empty the table after the last item of a set
      count_nxt = item_r.set_last ? '0 : count_new;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      chk_r       <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      chk_r       <= cmd.issue;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_r <= in_data;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: sv/order_keeping_duplicate_remover_top.sv
// A scan stops early at the first matching entry, else it reads every value held.
// A new item is accepted only after the previous one has finished its scan;
// the table is searched one entry per cycle through the single RAM read port.
// The result register lets the next item enter while a result waits.
// Reset (rst_n low, synchronous) empties the table and clears all handshakes;
// table contents are not cleared and need no clearing pass.
module order_keeping_duplicate_remover_top #(
  parameter int unsigned TABLE_DEPTH = okdr_pkg::TABLE_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  okdr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output okdr_pkg::out_item_t out_data
);

  import okdr_pkg::*;

  okdr_cmd_t cmd;
  okdr_sts_t sts;

  // Sequencer
  okdr_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Table, scan and result register
  okdr_dp #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule

FILE: sim/order_keeping_duplicate_remover_top_tb.sv
`timescale 1ns / 100ps

module order_keeping_duplicate_remover_top_tb;
  import okdr_pkg::*;

  localparam int unsigned DEPTH = TABLE_DEPTH_DEF;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_IDLE = 18;
  localparam logic [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // Predicted results, oldest first
  out_item_t dedup_results_q[$];

  // Own copy of the set table
  logic [VALUE_W-1:0] seen_tbl [DEPTH];
  int unsigned        seen_n;

  // Per-set pool of candidate values for random sets
  logic [VALUE_W-1:0] value_pool[$];

  int unsigned in_gap_max;
  int unsigned out_stall_max;
  int unsigned hold_request;
  int unsigned failures;
  int unsigned cycle_count;

  order_keeping_duplicate_remover_top #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  // Generate the 10 ns clock
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Work out the result of one item and advance the set table
  function automatic out_item_t dedup_predict(input in_item_t it);
    out_item_t r;
    logic      found;
    found = 1'b0;
    for (int i = 0; i < seen_n; i++) begin
      if (seen_tbl[i] == it.item_value) found = 1'b1;
    end
    r.echo_value    = it.item_value;
    r.keep_flag     = 1'b0;
    r.overflow_flag = 1'b0;
    if (!found) begin
      if (seen_n < DEPTH) begin
        seen_tbl[seen_n] = it.item_value;
        seen_n++;
        r.keep_flag = 1'b1;
      end else begin
        r.overflow_flag = 1'b1;
      end
    end
    r.distinct_count = DCOUNT_W'(seen_n);
    r.end_of_set     = it.set_last;
    if (it.set_last) seen_n = 0;
    return r;
  endfunction

  // Offer one item after a random gap and hold it until accepted
  task automatic send_value(input logic [VALUE_W-1:0] v, input logic last);
    in_item_t    it;
    int unsigned gap;
    it.item_value = v;
    it.set_last   = last;
    gap = (in_gap_max == 0) ? 0 : $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    dedup_results_q.push_back(dedup_predict(it));
  endtask

  // Drop valid and hold until every predicted result has arrived
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    while (dedup_results_q.size() != 0) @(posedge clk);
  endtask

  // Draw a value, mostly from the set's pool so that repeats are common
  function automatic logic [VALUE_W-1:0] draw_value();
    logic [VALUE_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: v = value_pool[$urandom_range(0, value_pool.size() - 1)];
      6: v = VALUE_W'($urandom_range(0, 15)) - 32'd8;
      7: v = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
      default: v = $urandom();
    endcase
    return v;
  endfunction

  task automatic fill_pool(input int unsigned n);
    value_pool.delete();
    repeat (n) begin
      if ($urandom_range(0, 2) == 0) value_pool.push_back(VALUE_W'($urandom_range(0, 7)) - 32'd4);
      else value_pool.push_back($urandom());
    end
  endtask

  task automatic send_random_set(input int unsigned len);
    fill_pool($urandom_range(1, len));
    for (int unsigned i = 0; i < len; i++) begin
      send_value(draw_value(), i == len - 1);
    end
  endtask

  // Extremes, repeats, one-item sets and zero with an empty table
  task automatic test_extremes();
    in_gap_max    = MAX_IDLE;
    out_stall_max = MAX_IDLE;
    send_value(32'd0, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(VAL_MAX, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(32'd0, 1'b0);
    send_value(32'd1, 1'b0);
    send_value(32'hAAAA_AAAA, 1'b0);
    send_value(32'h5555_5555, 1'b0);
    send_value(VAL_MAX, 1'b1);
    send_value(32'd5, 1'b1);
    send_value(32'd0, 1'b1);
    send_value(32'd7, 1'b0);
    send_value(32'd7, 1'b0);
    send_value(32'd7, 1'b0);
    send_value(32'd7, 1'b1);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'hFFFF_FFFE, 1'b0);
    send_value(32'hFFFF_FFFF, 1'b0);
    send_value(32'h0000_0000, 1'b0);
    send_value(32'hFFFF_FFFE, 1'b1);
    wait_results_drained();
  endtask

  // Fill the table, then drop new values; the next set starts empty
  task automatic test_table_full();
    in_gap_max    = 2;
    out_stall_max = 2;
    for (int unsigned i = 0; i < DEPTH; i++) begin
      send_value(VALUE_W'(i) * 32'h0101_0103 ^ VAL_MIN, 1'b0);
    end
    send_value(32'h1234_5679, 1'b0);
    send_value(32'h1234_5679, 1'b0);
    send_value(VAL_MIN, 1'b0);
    send_value(32'h0101_0103 ^ VAL_MIN, 1'b0);
    send_value(32'hDEAD_BEEF, 1'b1);
    send_value(32'h1234_5679, 1'b0);
    send_value(32'hDEAD_BEEF, 1'b1);
    wait_results_drained();
  endtask

  // Sets around the table size with random repeats mixed in
  task automatic test_near_full_sets();
    int unsigned n_new;
    int unsigned base;
    in_gap_max    = 1;
    out_stall_max = 1;
    for (int k = 0; k < 2; k++) begin
      n_new = DEPTH - 1 + $urandom_range(0, 3);
      base  = $urandom();
      for (int unsigned i = 0; i < n_new; i++) begin
        send_value(VALUE_W'(base + i * 32'h0001_0003), 1'b0);
        if ($urandom_range(0, 15) == 0) send_value(VALUE_W'(base), 1'b0);
      end
      send_value(VALUE_W'(base + 32'h0001_0003), 1'b1);
    end
    wait_results_drained();
  endtask

  // Mostly short sets with random idling, some with none
  task automatic test_random_sets(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 19))
        0:       len = 1;
        1, 2, 3: len = $urandom_range(25, 60);
        default: len = $urandom_range(2, 24);
      endcase
      in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : MAX_IDLE;
      send_random_set(len);
      sent += len;
    end
    wait_results_drained();
  endtask

  // Hold the receiver off while the sender keeps offering items
  task automatic test_back_pressure();
    in_gap_max    = 0;
    out_stall_max = MAX_IDLE;
    hold_request  = 400;
    send_random_set(20);
    send_random_set(20);
    wait_results_drained();
  endtask

  // No idling on either side
  task automatic test_no_idle();
    in_gap_max    = 0;
    out_stall_max = 0;
    repeat (4) send_random_set($urandom_range(8, 16));
    wait_results_drained();
  endtask

  // Receiver: stall a random number of cycles before each result
  initial begin : receiver
    int unsigned stall;
    out_ready <= 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      stall = (out_stall_max == 0) ? 0 : $urandom_range(0, out_stall_max);
      if (hold_request != 0) begin
        stall        = hold_request;
        hold_request = 0;
      end
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (dedup_results_q.size() == 0) begin
        $error("result with none expected: echo_value %0d", $signed(out_data.echo_value));
        failures++;
      end else begin
        want = dedup_results_q.pop_front();
        if (out_data.echo_value !== want.echo_value) begin
          $error("echo_value: expected %0d, got %0d",
                 $signed(want.echo_value), $signed(out_data.echo_value));
          failures++;
        end
        if (out_data.keep_flag !== want.keep_flag) begin
          $error("keep_flag: expected %0b, got %0b", want.keep_flag, out_data.keep_flag);
          failures++;
        end
        if (out_data.distinct_count !== want.distinct_count) begin
          $error("distinct_count: expected %0d, got %0d",
                 want.distinct_count, out_data.distinct_count);
          failures++;
        end
        if (out_data.overflow_flag !== want.overflow_flag) begin
          $error("overflow_flag: expected %0b, got %0b",
                 want.overflow_flag, out_data.overflow_flag);
          failures++;
        end
        if (out_data.end_of_set !== want.end_of_set) begin
          $error("end_of_set: expected %0b, got %0b", want.end_of_set, out_data.end_of_set);
          failures++;
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    failures      = 0;
    cycle_count   = 0;
    hold_request  = 0;
    seen_n        = 0;
    in_gap_max    = MAX_IDLE;
    out_stall_max = MAX_IDLE;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_extremes();
    test_table_full();
    test_near_full_sets();
    test_back_pressure();
    test_random_sets(450);
    test_no_idle();
    test_random_sets(200);

    // Let any stray result surface
    repeat (DEPTH + 8) @(posedge clk);
    if (dedup_results_q.size() != 0) begin
      $error("%0d results never arrived", dedup_results_q.size());
      failures++;
    end
    if (failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/okdr_pkg.sv
sv/okdr_ram.sv
sv/okdr_ctrl.sv
sv/okdr_dp.sv
sv/order_keeping_duplicate_remover_top.sv
sim/order_keeping_duplicate_remover_top_tb.sv
